[rtl/cidt_pkg.sv]
// Package with types, codes and conversion constants of the date-time resource.
`timescale 1ns / 1ps

package cidt_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_APDU = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_IGNORED  = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;

  // Date-time enquiry tag.
  localparam logic [7:0] TAG_0 = 8'h9f;
  localparam logic [7:0] TAG_1 = 8'h84;
  localparam logic [7:0] TAG_2 = 8'h40;

  // Day split: 86400 = 128 * 675, quotient by a scaled reciprocal of 675.
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam int          DAY_SHIFT = 35;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [15:0] MJD_EPOCH = 16'd40587;

  // Hour split: 3600 = 16 * 225; minute split: 60 = 4 * 15.
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  typedef enum logic [1:0] {
    MODE_STARTED = 2'd0,
    MODE_SEND    = 2'd1
  } mode_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } res_t;

  // Two BCD digits of a value below 60.
  function automatic logic [6:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - 6'(tens) * 6'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

[rtl/cidt_if.sv]
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps

interface cidt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  tag_byte_0;
  logic [7:0]  tag_byte_1;
  logic [7:0]  tag_byte_2;
  logic        has_data;
  logic [7:0]  first_data_byte;
  logic [31:0] unix_seconds;

  modport source (output valid, op, tag_byte_0, tag_byte_1, tag_byte_2, has_data,
                  first_data_byte, unix_seconds, input ready);
  modport sink (input valid, op, tag_byte_0, tag_byte_1, tag_byte_2, has_data,
                first_data_byte, unix_seconds, output ready);
endinterface

interface cidt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] mjd;
  logic [5:0]  hours_bcd;
  logic [6:0]  minutes_bcd;
  logic [6:0]  seconds_bcd;

  modport source (output valid, kind, mjd, hours_bcd, minutes_bcd, seconds_bcd,
                  input ready);
  modport sink (input valid, kind, mjd, hours_bcd, minutes_bcd, seconds_bcd,
                output ready);
endinterface

[rtl/cidt_ctrl.sv]
// Session mode and repeat timer control, deciding the result of each transaction.
`timescale 1ns / 1ps

module cidt_ctrl import cidt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] op,
  input  logic [7:0] tag_byte_0,
  input  logic [7:0] tag_byte_1,
  input  logic [7:0] tag_byte_2,
  input  logic       has_data,
  input  logic [7:0] first_data_byte,
  output res_t       res
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] interval_r, interval_nxt;
  logic       running_r, running_nxt;
  logic [7:0] left_r, left_nxt;
  logic       enquiry;
  logic       expire;

  assign enquiry = (tag_byte_0 == TAG_0) && (tag_byte_1 == TAG_1) && (tag_byte_2 == TAG_2);
  assign expire  = running_r && (left_r <= 8'd1);

  always_comb begin
    mode_nxt     = mode_r;
    interval_nxt = interval_r;
    running_nxt  = running_r;
    left_nxt     = left_r;
    if (accept) begin
      unique case (op)
        OP_APDU: begin
          if (enquiry) begin
            running_nxt  = 1'b0;
            left_nxt     = 8'd0;
            interval_nxt = has_data ? first_data_byte : 8'd0;
            mode_nxt     = MODE_SEND;
          end
        end
        OP_POLL: begin
          if (mode_r == MODE_SEND && interval_r != 8'd0) begin
            running_nxt = 1'b1;
            left_nxt    = interval_r;
          end
        end
        OP_TICK: begin
          if (running_r) begin
            if (!expire) begin
              left_nxt = left_r - 8'd1;
            end else if (interval_r != 8'd0) begin
              running_nxt = 1'b1;
              left_nxt    = interval_r;
            end else begin
              running_nxt = 1'b0;
              left_nxt    = 8'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.valid = 1'b0;
    res.kind  = KIND_RESPONSE;
    unique case (op)
      OP_APDU: begin
        res.valid = accept;
        res.kind  = enquiry ? KIND_ACCEPTED : KIND_IGNORED;
      end
      OP_POLL: res.valid = accept && (mode_r == MODE_SEND);
      OP_TICK: res.valid = accept && expire;
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_STARTED;
      interval_r <= 8'd0;
      running_r  <= 1'b0;
      left_r     <= 8'd0;
    end else begin
      mode_r     <= mode_nxt;
      interval_r <= interval_nxt;
      running_r  <= running_nxt;
      left_r     <= left_nxt;
    end
  end

  a_running_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (left_r != 8'd0) && (interval_r != 8'd0))
    else $error("running timer without count or interval");

  a_started_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STARTED) |-> !running_r)
    else $error("timer running before enquiry");

  a_enquiry_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_APDU && enquiry) |=> (mode_r == MODE_SEND) && !running_r)
    else $error("enquiry did not stop the timer");

endmodule

[rtl/cidt_conv.sv]
// Pipeline converting Unix seconds into MJD and BCD time, ending in the output register.
`timescale 1ns / 1ps

module cidt_conv import cidt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  res_t        res_in,
  input  logic [31:0] now,
  input  logic        out_ready,
  output logic        advance,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_mjd,
  output logic [5:0]  out_hours_bcd,
  output logic [6:0]  out_minutes_bcd,
  output logic [6:0]  out_seconds_bcd
);

  // Stage valid and kind bits, a (day quotient) through f (output).
  res_t        a_res_r, b_res_r, c_res_r, d_res_r, e_res_r, f_res_r;
  logic [31:0] a_now_r;
  logic [15:0] a_q_r;
  logic [16:0] b_rem_r, c_rem_r;
  logic [15:0] b_mjd_r, c_mjd_r, d_mjd_r, e_mjd_r, f_mjd_r;
  logic [4:0]  c_hh_r, d_hh_r, e_hh_r;
  logic [11:0] d_r2_r, e_r2_r;
  logic [5:0]  e_mm_r;
  logic [5:0]  f_hh_bcd_r;
  logic [6:0]  f_mm_bcd_r, f_ss_bcd_r;

  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic [25:0] hour_prod;
  logic [16:0] hour_secs;
  logic [20:0] min_prod;
  logic [11:0] ss_full;
  logic [6:0]  hh_bcd, mm_bcd, ss_bcd;
  logic        resp;

  assign advance = !f_res_r.valid || out_ready;

  assign day_prod  = 51'(now[31:7]) * 51'(DAY_RECIP);
  assign day_secs  = 32'(a_q_r) * 32'(SECS_PER_DAY);
  assign hour_prod = 26'(b_rem_r[16:4]) * 26'(HOUR_RECIP);
  assign hour_secs = 17'(c_hh_r) * SECS_PER_HOUR;
  assign min_prod  = 21'(d_r2_r[11:2]) * 21'(MIN_RECIP);
  assign ss_full   = e_r2_r - 12'(e_mm_r) * SECS_PER_MIN;
  assign hh_bcd    = to_bcd({1'b0, e_hh_r});
  assign mm_bcd    = to_bcd(e_mm_r);
  assign ss_bcd    = to_bcd(ss_full[5:0]);
  assign resp      = e_res_r.kind == KIND_RESPONSE;

  always_ff @(posedge clk) begin
    if (advance) begin
      a_now_r    <= now;
      a_q_r      <= day_prod[DAY_SHIFT +: 16];
      b_rem_r    <= 17'(a_now_r - day_secs);
      b_mjd_r    <= a_q_r + MJD_EPOCH;
      c_rem_r    <= b_rem_r;
      c_mjd_r    <= b_mjd_r;
      c_hh_r     <= hour_prod[24:20];
      d_r2_r     <= 12'(c_rem_r - hour_secs);
      d_mjd_r    <= c_mjd_r;
      d_hh_r     <= c_hh_r;
      e_r2_r     <= d_r2_r;
      e_mm_r     <= min_prod[19:14];
      e_mjd_r    <= d_mjd_r;
      e_hh_r     <= d_hh_r;
      f_mjd_r    <= resp ? e_mjd_r : 16'd0;
      f_hh_bcd_r <= resp ? hh_bcd[5:0] : 6'd0;
      f_mm_bcd_r <= resp ? mm_bcd : 7'd0;
      f_ss_bcd_r <= resp ? ss_bcd : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_res_r <= '0;
      b_res_r <= '0;
      c_res_r <= '0;
      d_res_r <= '0;
      e_res_r <= '0;
      f_res_r <= '0;
    end else if (advance) begin
      a_res_r <= res_in;
      b_res_r <= a_res_r;
      c_res_r <= b_res_r;
      d_res_r <= c_res_r;
      e_res_r <= d_res_r;
      f_res_r <= e_res_r;
    end
  end

  assign out_valid       = f_res_r.valid;
  assign out_kind        = f_res_r.kind;
  assign out_mjd         = f_mjd_r;
  assign out_hours_bcd   = f_hh_bcd_r;
  assign out_minutes_bcd = f_mm_bcd_r;
  assign out_seconds_bcd = f_ss_bcd_r;

  a_apdu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_RESPONSE) |->
      (out_mjd == 16'd0) && (out_hours_bcd == 6'd0) &&
      (out_minutes_bcd == 7'd0) && (out_seconds_bcd == 7'd0))
    else $error("APDU report carries date-time fields");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seconds_bcd[3:0] <= 4'd9) && (out_minutes_bcd[3:0] <= 4'd9) &&
      (out_hours_bcd[3:0] <= 4'd9) && (out_seconds_bcd[6:4] <= 3'd5) &&
      (out_minutes_bcd[6:4] <= 3'd5) && (out_hours_bcd[5:4] <= 2'd2))
    else $error("invalid BCD digit");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && !advance || out_valid)
    else $error("stalled result lost");

endmodule

[rtl/ci_date_time_resource.sv]
// Top level of the common-interface date-time resource.
//
// Input channel in_ch carries one transaction per item: an incoming APDU
// (its three tag bytes and first data byte), an action poll or a one-second
// tick, each with the current Unix time. Result channel out_ch gives at most
// one transaction per input: an accepted or ignored report for every APDU,
// and a date-time response (MJD and BCD hours, minutes, seconds) for a poll
// in the send state or for an expiring repeat timer.
// Session mode and timer are updated in the cycle an input is accepted, so
// one input can be taken in every cycle while the receiver does not stall.
// The conversion runs through a six-register pipeline, and the throughput
// is one item per cycle while the output register is not stalled.
// Inputs that give no result leave a bubble and nothing appears for them.
// When the receiver stalls, the output register holds its result and the
// whole pipeline holds with it, so in_ch.ready drops until out_ch.ready rises.
// Synchronous reset returns the session to the started mode with the timer
// stopped and the interval cleared, and empties the pipeline.
`timescale 1ns / 1ps

module ci_date_time_resource import cidt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cidt_in_if.sink    in_ch,
  cidt_out_if.source out_ch
);

  res_t res;
  logic advance;
  logic accept;

  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  cidt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .op              (in_ch.op),
    .tag_byte_0      (in_ch.tag_byte_0),
    .tag_byte_1      (in_ch.tag_byte_1),
    .tag_byte_2      (in_ch.tag_byte_2),
    .has_data        (in_ch.has_data),
    .first_data_byte (in_ch.first_data_byte),
    .res             (res)
  );

  cidt_conv u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_in          (res),
    .now             (in_ch.unix_seconds),
    .out_ready       (out_ch.ready),
    .advance         (advance),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_mjd         (out_ch.mjd),
    .out_hours_bcd   (out_ch.hours_bcd),
    .out_minutes_bcd (out_ch.minutes_bcd),
    .out_seconds_bcd (out_ch.seconds_bcd)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the date-time resource: scoreboard, drivers and monitor.
`timescale 1ns / 1ps

module tb import cidt_pkg::*; ();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1350;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tag_byte_0;
    logic [7:0]  tag_byte_1;
    logic [7:0]  tag_byte_2;
    logic        has_data;
    logic [7:0]  first_data_byte;
    logic [31:0] unix_seconds;
  } dt_request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mjd;
    logic [5:0]  hours_bcd;
    logic [6:0]  minutes_bcd;
    logic [6:0]  seconds_bcd;
  } dt_result_t;

  // Tracks the session and timer state and keeps the results still owed by the block.
  class dt_scoreboard;
    mode_t       mode;
    logic [7:0]  interval;
    logic        running;
    logic [7:0]  secs_left;
    dt_result_t  expected_results[$];
    int          errors;
    int          item_count;

    function new();
      mode = MODE_STARTED;
      interval = '0;
      running = 1'b0;
      secs_left = '0;
      errors = 0;
      item_count = 0;
    endfunction

    function logic [7:0] two_digit_bcd(input int unsigned v);
      return 8'((v / 10) * 16 + v % 10);
    endfunction

    function dt_result_t predict_response(input logic [31:0] now);
      dt_result_t res;
      logic [31:0] rem;
      rem = now % SECS_PER_DAY;
      res.kind = KIND_RESPONSE;
      res.mjd = 16'(now / SECS_PER_DAY + MJD_EPOCH);
      res.hours_bcd = 6'(two_digit_bcd(rem / SECS_PER_HOUR));
      res.minutes_bcd = 7'(two_digit_bcd((rem % SECS_PER_HOUR) / SECS_PER_MIN));
      res.seconds_bcd = 7'(two_digit_bcd(rem % SECS_PER_MIN));
      if (interval != 8'd0) begin
        running = 1'b1;
        secs_left = interval;
      end
      return res;
    endfunction

    function void note_request(input dt_request_t req);
      dt_result_t res;
      bit produced;
      res = '0;
      produced = 1'b0;
      case (req.op)
        OP_APDU: begin
          produced = 1'b1;
          if (req.tag_byte_0 == TAG_0 && req.tag_byte_1 == TAG_1 && req.tag_byte_2 == TAG_2) begin
            running = 1'b0;
            secs_left = '0;
            interval = req.has_data ? req.first_data_byte : 8'd0;
            mode = MODE_SEND;
            res.kind = KIND_ACCEPTED;
          end else begin
            res.kind = KIND_IGNORED;
          end
        end
        OP_POLL: begin
          if (mode == MODE_SEND) begin
            res = predict_response(req.unix_seconds);
            produced = 1'b1;
          end
        end
        OP_TICK: begin
          if (running) begin
            if (secs_left > 8'd1) begin
              secs_left = secs_left - 8'd1;
            end else begin
              running = 1'b0;
              secs_left = '0;
              res = predict_response(req.unix_seconds);
              produced = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (produced) expected_results.push_back(res);
      item_count++;
    endfunction

    function void check_result(input dt_result_t got);
      dt_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d mjd %0d", got.kind, got.mjd);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.mjd !== want.mjd) begin
        $error("mjd: expected %0d, actual %0d", want.mjd, got.mjd);
        errors++;
      end
      if (got.hours_bcd !== want.hours_bcd) begin
        $error("hours_bcd: expected %h, actual %h", want.hours_bcd, got.hours_bcd);
        errors++;
      end
      if (got.minutes_bcd !== want.minutes_bcd) begin
        $error("minutes_bcd: expected %h, actual %h", want.minutes_bcd, got.minutes_bcd);
        errors++;
      end
      if (got.seconds_bcd !== want.seconds_bcd) begin
        $error("seconds_bcd: expected %h, actual %h", want.seconds_bcd, got.seconds_bcd);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   gaps_on;
  bit   stalls_on;
  bit   hold_request;

  dt_scoreboard sb;

  cidt_in_if  in_ch();
  cidt_out_if out_ch();

  ci_date_time_resource dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.kind, out_ch.mjd, out_ch.hours_bcd, out_ch.minutes_bcd,
                        out_ch.seconds_bcd});
    end
  end

  // The receiver stalls at random and, on request, holds off for a long stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !(stalls_on && $urandom_range(0, 99) < 29);
    end
  end

  task automatic send_item(input dt_request_t req);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= req.op;
    in_ch.tag_byte_0 <= req.tag_byte_0;
    in_ch.tag_byte_1 <= req.tag_byte_1;
    in_ch.tag_byte_2 <= req.tag_byte_2;
    in_ch.has_data <= req.has_data;
    in_ch.first_data_byte <= req.first_data_byte;
    in_ch.unix_seconds <= req.unix_seconds;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] t0, input logic [7:0] t1,
                         input logic [7:0] t2, input logic has, input logic [7:0] data,
                         input logic [31:0] now);
    send_item('{op, t0, t1, t2, has, data, now});
  endtask

  function automatic dt_request_t random_request();
    dt_request_t req;
    int unsigned pick;
    req = '{OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
            8'($urandom), $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      req.op = OP_APDU;
      if ($urandom_range(0, 3) != 0) begin
        req.tag_byte_0 = TAG_0;
        req.tag_byte_1 = TAG_1;
        req.tag_byte_2 = TAG_2;
        if (req.has_data && $urandom_range(0, 3) != 0) begin
          req.first_data_byte = 8'($urandom_range(0, 4));
        end
      end
    end else if (pick < 30) begin
      req.op = OP_POLL;
    end else if (pick < 93) begin
      req.op = OP_TICK;
    end else begin
      req.op = OP_UNUSED;
    end
    return req;
  endfunction

  initial begin
    dt_request_t req;
    sb = new();
    cycle_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_APDU;
    in_ch.tag_byte_0 <= '0;
    in_ch.tag_byte_1 <= '0;
    in_ch.tag_byte_2 <= '0;
    in_ch.has_data <= 1'b0;
    in_ch.first_data_byte <= '0;
    in_ch.unix_seconds <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd100);
    send_op(OP_UNUSED, TAG_0, TAG_1, TAG_2, 1'b1, 8'h05, 32'd200);
    send_op(OP_APDU, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0);
    send_op(OP_APDU, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 32'hffffffff);
    send_op(OP_APDU, TAG_0, TAG_1, 8'h41, 1'b1, 8'h03, 32'd5);
    send_op(OP_APDU, TAG_0, TAG_1, TAG_2, 1'b0, 8'hff, 32'hffffffff);
    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0);
    send_op(OP_POLL, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 32'hffffffff);
    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd86399);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd86400);
    send_op(OP_APDU, TAG_0, TAG_1, TAG_2, 1'b1, 8'h01, 32'd0);
    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd1700000000);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd1700000001);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd1700000002);
    send_op(OP_APDU, TAG_0, TAG_1, TAG_2, 1'b1, 8'hff, 32'd0);
    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd2147483647);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd2147483648);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 32'd2147483649);
    send_op(OP_APDU, TAG_0, TAG_1, TAG_2, 1'b1, 8'h02, $urandom);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, $urandom);
    send_op(OP_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, $urandom);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, $urandom);
    send_op(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, $urandom);

    // The receiver holds off while APDU transactions keep coming, so the block must backpressure.
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) begin
      req = random_request();
      req.op = OP_APDU;
      send_item(req);
    end
    gaps_on = 1'b1;

    while (sb.item_count < ITEM_TARGET) begin
      gaps_on = !(sb.item_count >= 500 && sb.item_count < 800);
      stalls_on = gaps_on;
      send_item(random_request());
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    in_ch.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
